FILE: src/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg: shared types and constants of the Huffman stream decoder
// Beat types of both channels, result status codes, node table and stack
// sizes, and the control bundles that pass between the decoder sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsd_pkg;

  localparam int NODE_DEPTH  = 512;
  localparam int STACK_DEPTH = 256;

  localparam int NODE_AW  = $clog2(NODE_DEPTH);
  localparam int NF_W     = $clog2(NODE_DEPTH + 1);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] STATUS_SYMBOL    = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } stream_beat_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] status;
    logic       last_of_run;
  } result_beat_t;

  typedef struct packed {
    logic       bit_valid;
    logic       end_valid;
    logic       data_bit;
    logic [2:0] bit_idx;
    logic       last;
  } feed_t;

  typedef struct packed {
    logic step;
    logic drop;
  } feed_ctrl_t;

  typedef struct packed {
    logic       push;
    logic       flush;
    logic [7:0] symbol;
    logic [1:0] status;
  } res_req_t;

endpackage

`default_nettype wire

FILE: src/hsd_bit_feed.sv
// ----------------------------------------------------------------------------
// hsd_bit_feed: input byte shifter
// Takes one stream beat, presents its bits MSB first one at a time (the
// core may drop the rest), then an end-of-byte step before the next beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsd_bit_feed (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stream_valid,
  output logic                  stream_stall,
  input  hsd_pkg::stream_beat_t stream,
  input  hsd_pkg::feed_ctrl_t   ctrl,
  output hsd_pkg::feed_t        feed
);
  import hsd_pkg::*;

  typedef enum logic [2:0] {
    FD_IDLE = 3'b001,
    FD_BITS = 3'b010,
    FD_END  = 3'b100
  } fd_state_t;

  fd_state_t  state;
  logic [7:0] shreg;
  logic [2:0] bit_idx;
  logic       last;

  assign stream_stall = (state != FD_IDLE);

  assign feed.bit_valid = (state == FD_BITS);
  assign feed.end_valid = (state == FD_END);
  assign feed.data_bit  = shreg[7];
  assign feed.bit_idx   = bit_idx;
  assign feed.last      = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FD_IDLE;
    end else begin
      unique case (state)
        FD_IDLE: begin
          if (stream_valid) begin
            state <= FD_BITS;
          end
        end
        FD_BITS: begin
          if (ctrl.drop || (ctrl.step && bit_idx == 3'd7)) begin
            state <= FD_END;
          end
        end
        FD_END: begin
          if (ctrl.step) begin
            state <= FD_IDLE;
          end
        end
        default: begin
          state <= FD_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == FD_IDLE && stream_valid) begin
      shreg   <= stream.data_byte;
      bit_idx <= 3'd0;
      last    <= stream.last_byte;
    end else if (state == FD_BITS && ctrl.step) begin
      shreg   <= {shreg[6:0], 1'b0};
      bit_idx <= bit_idx + 3'd1;
    end
  end

endmodule

`default_nettype wire

FILE: src/hsd_core.sv
// ----------------------------------------------------------------------------
// hsd_core: header parser, tree builder and tree walker
// Consumes one bit per step. Rebuilds the preorder tree into the node
// memories with a pending-parent stack, then walks it for data bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsd_core (
  input  logic                clk,
  input  logic                rst,
  input  hsd_pkg::feed_t      feed,
  output hsd_pkg::feed_ctrl_t ctrl,
  input  logic                blocked,
  output hsd_pkg::res_req_t   req
);
  import hsd_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_TREE   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    SUB_BIT  = 3'b001,
    SUB_POP  = 3'b010,
    SUB_EVAL = 3'b100
  } sub_t;

  phase_t             phase, phase_next;
  sub_t               sub, sub_next;
  logic [1:0]         header_bit_count, header_bit_count_next;
  logic [2:0]         pad_count, pad_count_next;
  logic [7:0]         leaf_shift, leaf_shift_next;
  logic [3:0]         leaf_bit_count, leaf_bit_count_next;
  logic [NF_W-1:0]    next_free_node, next_free_node_next;
  logic [SP_W-1:0]    stack_pointer, stack_pointer_next;
  logic [NODE_AW:0]   pending_slot, pending_slot_next;
  logic               root_is_leaf, root_is_leaf_next;
  logic               trunc_sent, trunc_sent_next;
  logic [NODE_AW-1:0] cur_left, cur_left_next;
  logic [NODE_AW-1:0] cur_right, cur_right_next;
  logic [NODE_AW-1:0] root_left, root_left_next;
  logic [NODE_AW-1:0] root_right, root_right_next;
  logic [7:0]         root_sym, root_sym_next;

  logic               flag_mem  [NODE_DEPTH];
  logic [NODE_AW-1:0] left_mem  [NODE_DEPTH];
  logic [NODE_AW-1:0] right_mem [NODE_DEPTH];
  logic [7:0]         sym_mem   [NODE_DEPTH];
  logic [NODE_AW-1:0] stack_mem [STACK_DEPTH];

  logic               flag_rd;
  logic [NODE_AW-1:0] left_rd, right_rd;
  logic [7:0]         sym_rd;
  logic [NODE_AW-1:0] stack_rd;

  logic               flag_we, left_we, right_we, sym_we, stack_we;
  logic [NODE_AW-1:0] flag_wa, link_wa, sym_wa;
  logic [STACK_AW-1:0] stack_wa, stack_ra;
  logic [SP_W-1:0]    stack_ptr_m1;

  logic [NODE_AW-1:0] new_node, leaf_node, parent, child;
  logic [3:0]         pad_sum;
  logic               pad_known, drop_bit, marker_ovf;
  logic               do_marker, do_leaf, hold;
  feed_ctrl_t         ctrl_raw;
  res_req_t           req_raw;

  assign new_node     = next_free_node[NODE_AW-1:0];
  assign leaf_node    = new_node - 1'b1;
  assign parent       = pending_slot[NODE_AW:1];
  assign child        = feed.data_bit ? cur_right : cur_left;
  assign stack_ptr_m1 = stack_pointer - 1'b1;
  assign stack_ra     = stack_ptr_m1[STACK_AW-1:0];
  assign stack_wa     = stack_pointer[STACK_AW-1:0];
  assign pad_sum      = {1'b0, feed.bit_idx} + {1'b0, pad_count};
  assign pad_known    = (phase != PH_HEADER) || (header_bit_count == 2'd3);
  assign drop_bit     = (phase == PH_ERROR) || (feed.last && pad_known && pad_sum[3]);
  assign marker_ovf   = (next_free_node >= NF_W'(NODE_DEPTH)) ||
                        (!feed.data_bit && stack_pointer >= SP_W'(STACK_DEPTH));

  assign hold = blocked && (req_raw.push || req_raw.flush);

  always_comb begin
    ctrl       = ctrl_raw;
    req        = req_raw;
    ctrl.step  = ctrl_raw.step && !hold;
    ctrl.drop  = ctrl_raw.drop && !hold;
    req.push   = req_raw.push && !hold;
    req.flush  = req_raw.flush && !hold;
  end

  always_comb begin
    phase_next            = phase;
    sub_next              = sub;
    header_bit_count_next = header_bit_count;
    pad_count_next        = pad_count;
    leaf_shift_next       = leaf_shift;
    leaf_bit_count_next   = leaf_bit_count;
    next_free_node_next   = next_free_node;
    stack_pointer_next    = stack_pointer;
    pending_slot_next     = pending_slot;
    root_is_leaf_next     = root_is_leaf;
    trunc_sent_next       = trunc_sent;
    cur_left_next         = cur_left;
    cur_right_next        = cur_right;
    root_left_next        = root_left;
    root_right_next       = root_right;
    root_sym_next         = root_sym;
    ctrl_raw              = '0;
    req_raw               = '0;
    req_raw.status        = STATUS_SYMBOL;
    flag_we               = 1'b0;
    left_we               = 1'b0;
    right_we              = 1'b0;
    sym_we                = 1'b0;
    stack_we              = 1'b0;
    flag_wa               = new_node;
    link_wa               = parent;
    sym_wa                = leaf_node;
    do_marker             = 1'b0;
    do_leaf               = 1'b0;

    priority if (sub == SUB_POP) begin
      pending_slot_next = {stack_rd, 1'b1};
      sub_next          = SUB_BIT;
    end else if (sub == SUB_EVAL) begin
      ctrl_raw.step = 1'b1;
      sub_next      = SUB_BIT;
      if (flag_rd) begin
        req_raw.push   = 1'b1;
        req_raw.symbol = sym_rd;
        cur_left_next  = root_left;
        cur_right_next = root_right;
      end else begin
        cur_left_next  = left_rd;
        cur_right_next = right_rd;
      end
    end else if (feed.bit_valid) begin
      if (drop_bit) begin
        ctrl_raw.drop = 1'b1;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            ctrl_raw.step = 1'b1;
            if (header_bit_count != 2'd3) begin
              pad_count_next        = {pad_count[1:0], feed.data_bit};
              header_bit_count_next = header_bit_count + 2'd1;
            end else begin
              root_is_leaf_next = feed.data_bit;
              phase_next        = PH_TREE;
              do_marker         = 1'b1;
            end
          end
          PH_TREE: begin
            ctrl_raw.step = 1'b1;
            if (leaf_bit_count == 4'd0) begin
              do_marker = 1'b1;
            end else begin
              do_leaf = 1'b1;
            end
          end
          PH_DATA: begin
            if (root_is_leaf) begin
              ctrl_raw.step  = 1'b1;
              req_raw.push   = 1'b1;
              req_raw.symbol = root_sym;
            end else begin
              sub_next = SUB_EVAL;
            end
          end
          default: begin
            ctrl_raw.drop = 1'b1;
          end
        endcase
      end
    end else if (feed.end_valid) begin
      if (feed.last && (phase == PH_HEADER || phase == PH_TREE) && !trunc_sent) begin
        req_raw.push    = 1'b1;
        req_raw.status  = STATUS_TRUNCATED;
        trunc_sent_next = 1'b1;
      end else begin
        req_raw.flush   = 1'b1;
        ctrl_raw.step   = 1'b1;
        trunc_sent_next = 1'b0;
        if (feed.last) begin
          phase_next            = PH_HEADER;
          header_bit_count_next = 2'd0;
          pad_count_next        = 3'd0;
          leaf_bit_count_next   = 4'd0;
          next_free_node_next   = '0;
          stack_pointer_next    = '0;
          pending_slot_next     = '0;
          root_is_leaf_next     = 1'b0;
        end
      end
    end else begin
      sub_next = SUB_BIT;
    end

    if (do_marker) begin
      if (marker_ovf) begin
        req_raw.push   = 1'b1;
        req_raw.status = STATUS_OVERFLOW;
        phase_next     = PH_ERROR;
      end else begin
        next_free_node_next = next_free_node + 1'b1;
        flag_we             = 1'b1;
        if (next_free_node != '0) begin
          if (pending_slot[0]) begin
            right_we = 1'b1;
            if (parent == '0) begin
              root_right_next = new_node;
            end
          end else begin
            left_we = 1'b1;
            if (parent == '0) begin
              root_left_next = new_node;
            end
          end
        end
        if (feed.data_bit) begin
          leaf_shift_next     = 8'd0;
          leaf_bit_count_next = 4'd1;
        end else begin
          stack_we           = 1'b1;
          stack_pointer_next = stack_pointer + 1'b1;
          pending_slot_next  = {new_node, 1'b0};
        end
      end
    end

    if (do_leaf) begin
      leaf_shift_next     = {leaf_shift[6:0], feed.data_bit};
      leaf_bit_count_next = leaf_bit_count + 4'd1;
      if (leaf_bit_count == 4'd8) begin
        sym_we              = 1'b1;
        leaf_bit_count_next = 4'd0;
        if (leaf_node == '0) begin
          root_sym_next = leaf_shift_next;
        end
        if (stack_pointer == '0) begin
          phase_next     = PH_DATA;
          cur_left_next  = root_left;
          cur_right_next = root_right;
        end else begin
          stack_pointer_next = stack_ptr_m1;
          sub_next           = SUB_POP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      sub              <= SUB_BIT;
      header_bit_count <= 2'd0;
      pad_count        <= 3'd0;
      leaf_bit_count   <= 4'd0;
      next_free_node   <= '0;
      stack_pointer    <= '0;
      pending_slot     <= '0;
      root_is_leaf     <= 1'b0;
      trunc_sent       <= 1'b0;
    end else if (!hold) begin
      phase            <= phase_next;
      sub              <= sub_next;
      header_bit_count <= header_bit_count_next;
      pad_count        <= pad_count_next;
      leaf_bit_count   <= leaf_bit_count_next;
      next_free_node   <= next_free_node_next;
      stack_pointer    <= stack_pointer_next;
      pending_slot     <= pending_slot_next;
      root_is_leaf     <= root_is_leaf_next;
      trunc_sent       <= trunc_sent_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      leaf_shift <= leaf_shift_next;
      cur_left   <= cur_left_next;
      cur_right  <= cur_right_next;
      root_left  <= root_left_next;
      root_right <= root_right_next;
      root_sym   <= root_sym_next;
    end
  end

  always_ff @(posedge clk) begin
    if (flag_we && !hold) begin
      flag_mem[flag_wa] <= feed.data_bit;
    end
    if (left_we && !hold) begin
      left_mem[link_wa] <= new_node;
    end
    if (right_we && !hold) begin
      right_mem[link_wa] <= new_node;
    end
    if (sym_we && !hold) begin
      sym_mem[sym_wa] <= leaf_shift_next;
    end
    flag_rd  <= flag_mem[child];
    left_rd  <= left_mem[child];
    right_rd <= right_mem[child];
    sym_rd   <= sym_mem[child];
  end

  always_ff @(posedge clk) begin
    if (stack_we && !hold) begin
      stack_mem[stack_wa] <= new_node;
    end
    stack_rd <= stack_mem[stack_ra];
  end

`ifndef SYNTHESIS
  a_pop_returns: assert property (@(posedge clk) disable iff (rst)
    sub == SUB_POP |=> sub == SUB_BIT)
    else $error("pop step did not return to bit step");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (stack_pointer <= SP_W'(STACK_DEPTH)) && (next_free_node <= NF_W'(NODE_DEPTH)))
    else $error("stack or node allocation beyond depth");

  a_eval_in_walk: assert property (@(posedge clk) disable iff (rst)
    sub == SUB_EVAL |-> (phase == PH_DATA) && !root_is_leaf)
    else $error("tree walk step outside data phase");
`endif

endmodule

`default_nettype wire

FILE: src/hsd_out_stage.sv
// ----------------------------------------------------------------------------
// hsd_out_stage: result hold and output register
// Keeps the newest result back until the next one or the end of its byte
// shows whether it is the last of the run, then moves it to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsd_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  hsd_pkg::res_req_t     req,
  output logic                  blocked,
  output logic                  result_valid,
  input  logic                  result_stall,
  output hsd_pkg::result_beat_t result
);
  import hsd_pkg::*;

  logic       held_valid;
  logic [7:0] held_symbol;
  logic [1:0] held_status;
  logic       move;

  assign blocked = held_valid && result_valid && result_stall;
  assign move    = held_valid && (req.push || req.flush);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (req.push) begin
        held_valid <= 1'b1;
      end else if (req.flush) begin
        held_valid <= 1'b0;
      end
      if (move) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      held_symbol <= req.symbol;
      held_status <= req.status;
      if (held_valid) begin
        result.symbol      <= held_symbol;
        result.status      <= held_status;
        result.last_of_run <= 1'b0;
      end
    end else if (req.flush && held_valid) begin
      result.symbol      <= held_symbol;
      result.status      <= held_status;
      result.last_of_run <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    !(req.push && req.flush))
    else $error("push and flush in the same cycle");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && result_valid && result_stall |=> held_valid)
    else $error("held result lost while output stalled");
`endif

endmodule

`default_nettype wire

FILE: src/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder: Huffman decoder for files with a preorder tree
// Accepts compressed bytes, rebuilds the code tree from the file header and
// emits one decoded symbol per code, with overflow and truncation status.
// ----------------------------------------------------------------------------
// A byte is taken while the feed is idle; its header and tree bits are
// then consumed one per cycle unless the decoder pauses, and a closing
// end-of-byte step ends the byte. A stack pop step follows each leaf that
// has a pending right sibling, and a truncated final byte gets an extra
// step that reports the truncation. Each data bit needs an extra evaluation
// step because every tree step reads the node memory through a registered
// port; a tree that is a single leaf needs no read. Padding and the rest
// of a file after an overflow are dropped at once. Results leave through
// a one-entry hold and an output register; the decoder pauses on a result
// request while both are full and the output is stalled. After the final
// byte of a file every counter returns to its reset value and the next
// beat starts a new file. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_stream_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  stream_valid,
  output logic                  stream_stall,
  input  hsd_pkg::stream_beat_t stream,
  output logic                  result_valid,
  input  logic                  result_stall,
  output hsd_pkg::result_beat_t result
);
  import hsd_pkg::*;

  feed_t      feed;
  feed_ctrl_t ctrl;
  res_req_t   req;
  logic       blocked;

  hsd_bit_feed u_feed (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream       (stream),
    .ctrl         (ctrl),
    .feed         (feed)
  );

  hsd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed),
    .ctrl    (ctrl),
    .blocked (blocked),
    .req     (req)
  );

  hsd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .blocked      (blocked),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: bench/tb_huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_huffman_stream_decoder: self-checking bench for the Huffman decoder
// Builds compressed files bit by bit (pad field, preorder tree, data bits),
// sends them byte by byte with random gaps, predicts every result beat from
// a bit-level decoder model kept in the bench, and compares each result
// beat field by field while the output side stalls at random. Covers
// single-leaf trees, partial codes, padding, truncation and stack overflow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_huffman_stream_decoder;
  import hsd_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int FILE_BITS_MAX = 1024;
  localparam int DUE_DEPTH     = 1024;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_TREE   = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_ERROR  = 4'b1000
  } decode_phase_t;

  logic         clk;
  logic         rst;
  logic         stream_valid;
  logic         stream_stall;
  stream_beat_t stream_beat;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_beat_t result_beat;

  huffman_stream_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream       (stream_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_beat)
  );

  // Decoder state mirrored in the bench
  decode_phase_t dec_phase;
  logic [1:0]    hdr_bits_seen;
  logic [2:0]    pad_bits;
  logic [7:0]    sym_shift;
  logic [3:0]    sym_bits;
  logic [18:0]   node_mem [NODE_DEPTH];
  logic [9:0]    free_node;
  logic [8:0]    pending_mem [STACK_DEPTH];
  logic [8:0]    stack_ptr;
  logic [9:0]    pend_slot;
  logic [8:0]    walk_at;
  logic          root_leaf;

  result_beat_t  beat_results [8];
  int            beat_count;
  result_beat_t  due_mem [DUE_DEPTH];
  int            due_wr = 0;
  int            due_rd = 0;
  result_beat_t  want;
  bit            file_bits [FILE_BITS_MAX];
  int            file_len;
  int            beats_sent;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            idle_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void decoder_clear();
    dec_phase     = PH_HEADER;
    hdr_bits_seen = '0;
    pad_bits      = '0;
    sym_shift     = '0;
    sym_bits      = '0;
    free_node     = '0;
    stack_ptr     = '0;
    pend_slot     = '0;
    walk_at       = '0;
    root_leaf     = 1'b0;
  endfunction

  function automatic void emit_result(logic [7:0] sym, logic [1:0] st);
    result_beat_t r;
    r.symbol      = sym;
    r.status      = st;
    r.last_of_run = 1'b0;
    beat_results[beat_count] = r;
    beat_count++;
  endfunction

  function automatic void flag_overflow();
    emit_result(8'h00, STATUS_OVERFLOW);
    dec_phase = PH_ERROR;
  endfunction

  function automatic bit node_alloc(output logic [8:0] idx);
    logic [8:0] parent;
    idx = free_node[8:0];
    if (free_node >= NODE_DEPTH) return 1'b0;
    if (free_node != 0) begin
      parent = pend_slot[9:1];
      if (pend_slot[0]) node_mem[parent][8:0] = free_node[8:0];
      else node_mem[parent][17:9] = free_node[8:0];
    end
    free_node = free_node + 1'b1;
    return 1'b1;
  endfunction

  function automatic bit take_marker(logic b);
    logic [8:0] n;
    if (b) begin
      if (!node_alloc(n)) return 1'b0;
      sym_shift = '0;
      sym_bits  = 4'd1;
      return 1'b1;
    end
    if (stack_ptr >= STACK_DEPTH) return 1'b0;
    if (!node_alloc(n)) return 1'b0;
    node_mem[n] = '0;
    pending_mem[stack_ptr[7:0]] = n;
    stack_ptr = stack_ptr + 1'b1;
    pend_slot = {n, 1'b0};
    return 1'b1;
  endfunction

  function automatic bit tree_bit(logic b);
    logic [8:0] n;
    if (sym_bits == 0) return take_marker(b);
    sym_shift = {sym_shift[6:0], b};
    sym_bits  = sym_bits + 1'b1;
    if (sym_bits >= 4'd9) begin
      n = free_node[8:0] - 1'b1;
      node_mem[n] = {1'b1, 10'd0, sym_shift};
      sym_bits = '0;
      if (stack_ptr == 0) begin
        dec_phase = PH_DATA;
        walk_at   = '0;
      end else begin
        stack_ptr = stack_ptr - 1'b1;
        pend_slot = {pending_mem[stack_ptr[7:0]], 1'b1};
      end
    end
    return 1'b1;
  endfunction

  function automatic void walk_bit(logic b);
    logic [18:0] e;
    logic [8:0]  child;
    if (root_leaf) begin
      emit_result(node_mem[0][7:0], STATUS_SYMBOL);
      return;
    end
    e     = node_mem[walk_at];
    child = b ? e[8:0] : e[17:9];
    if (node_mem[child][18]) begin
      emit_result(node_mem[child][7:0], STATUS_SYMBOL);
      walk_at = '0;
    end else begin
      walk_at = child;
    end
  endfunction

  function automatic void decode_beat(stream_beat_t beat);
    int   i;
    int   k;
    logic b;
    logic pad_known;
    beat_count = 0;
    for (i = 0; i < 8; i++) begin
      b = beat.data_byte[7 - i];
      pad_known = (dec_phase != PH_HEADER) || (hdr_bits_seen == 2'd3);
      if (dec_phase == PH_ERROR) break;
      if (beat.last_byte && pad_known && i >= 8 - int'(pad_bits)) break;
      case (dec_phase)
        PH_HEADER: begin
          if (hdr_bits_seen < 2'd3) begin
            pad_bits      = {pad_bits[1:0], b};
            hdr_bits_seen = hdr_bits_seen + 1'b1;
          end else begin
            root_leaf = b;
            dec_phase = PH_TREE;
            if (!take_marker(b)) flag_overflow();
          end
        end
        PH_TREE: begin
          if (!tree_bit(b)) flag_overflow();
        end
        default: begin
          walk_bit(b);
        end
      endcase
    end
    if (beat.last_byte) begin
      if ((dec_phase == PH_HEADER || dec_phase == PH_TREE) && beat_count < 8)
        emit_result(8'h00, STATUS_TRUNCATED);
      decoder_clear();
    end
    if (beat_count > 0) beat_results[beat_count - 1].last_of_run = 1'b1;
    for (k = 0; k < beat_count; k++) begin
      due_mem[due_wr % DUE_DEPTH] = beat_results[k];
      due_wr++;
    end
  endfunction

  // File construction
  function automatic void put_bits(logic [31:0] value, int width);
    int k;
    for (k = width - 1; k >= 0; k--) begin
      file_bits[file_len] = value[k];
      file_len++;
    end
  endfunction

  function automatic void start_file();
    file_len = 0;
    repeat (3) put_bits($urandom_range(1), 1);
  endfunction

  function automatic logic [7:0] pick_symbol();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic void put_tree(int leaves);
    int internals;
    int slots;
    internals = leaves - 1;
    slots     = 1;
    while (slots > 0) begin
      if (internals > 0 && (slots == 1 || $urandom_range(1) == 1)) begin
        put_bits(0, 1);
        internals--;
        slots++;
      end else begin
        put_bits(1, 1);
        put_bits(pick_symbol(), 8);
        slots--;
      end
    end
  endfunction

  function automatic void set_pad();
    logic [2:0] pad;
    pad = 3'((8 - file_len % 8) % 8);
    file_bits[0] = pad[2];
    file_bits[1] = pad[1];
    file_bits[2] = pad[0];
  endfunction

  function automatic void build_file(int leaves, int data_len);
    start_file();
    put_tree(leaves);
    repeat (data_len) put_bits($urandom_range(1), 1);
    set_pad();
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic l);
    stream_beat_t beat;
    beat = '{data_byte: b, last_byte: l};
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 18) begin
      stream_valid <= 1'b0;
      @(negedge clk);
    end
    stream_valid <= 1'b1;
    stream_beat  <= beat;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    decode_beat(beat);
    beats_sent++;
  endtask

  task automatic send_file();
    logic [7:0] b;
    int         nbytes;
    int         k;
    int         j;
    nbytes = (file_len + 7) / 8;
    if (nbytes == 0) nbytes = 1;
    for (k = 0; k < nbytes; k++) begin
      for (j = 0; j < 8; j++)
        b[7 - j] = (8 * k + j < file_len) ? file_bits[8 * k + j] : 1'($urandom_range(1));
      send_beat(b, k == nbytes - 1);
    end
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    stream_valid <= 1'b0;
    while (due_wr != due_rd) @(negedge clk);
  endtask

  // Tests
  task automatic test_single_leaf_tree();
    start_file();
    put_bits(1, 1);
    put_bits(8'hFF, 8);
    repeat (16) put_bits($urandom_range(1), 1);
    set_pad();
    send_file();
    start_file();
    put_bits(1, 1);
    put_bits(8'h00, 8);
    repeat (5) put_bits($urandom_range(1), 1);
    set_pad();
    send_file();
  endtask

  task automatic test_two_leaf_tree();
    start_file();
    put_bits(0, 1);
    put_bits(1, 1);
    put_bits(8'h00, 8);
    put_bits(1, 1);
    put_bits(8'hFF, 8);
    repeat (20) put_bits($urandom_range(1), 1);
    set_pad();
    send_file();
  endtask

  task automatic test_partial_code();
    start_file();
    put_bits(0, 1);
    put_bits(0, 1);
    put_bits(1, 1);
    put_bits(8'h41, 8);
    put_bits(1, 1);
    put_bits(8'h42, 8);
    put_bits(1, 1);
    put_bits(8'h43, 8);
    put_bits(4'b1000, 4);
    put_bits(3'b110, 3);
    set_pad();
    send_file();
  endtask

  task automatic test_padding();
    start_file();
    put_bits(1, 1);
    put_bits(8'h5A, 8);
    repeat (5) put_bits($urandom_range(1), 1);
    set_pad();
    send_file();
  endtask

  task automatic test_truncated_stream();
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h10, 1'b1);
    build_file(3, 0);
    if (file_len > 14) file_len = 14;
    file_bits[0] = 1'b0;
    file_bits[1] = 1'b0;
    file_bits[2] = 1'b0;
    send_file();
  endtask

  task automatic test_random_files();
    int target;
    int kind;
    int leaves;
    int cut;
    int files;
    target  = beats_sent + 100;
    files   = 0;
    idle_on = 1'b0;
    while (beats_sent < target) begin
      if (beats_sent > target - 60) idle_on = 1'b1;
      kind = $urandom_range(99);
      if (kind < 75) begin
        leaves = ($urandom_range(99) < 15) ? 1 : $urandom_range(12, 2);
        build_file(leaves, $urandom_range(64));
      end else if (kind < 87) begin
        build_file($urandom_range(12, 1), $urandom_range(24));
        cut = $urandom_range(file_len, 1);
        file_len = cut;
        file_bits[0] = 1'($urandom_range(1));
        file_bits[1] = 1'($urandom_range(1));
        file_bits[2] = 1'($urandom_range(1));
      end else begin
        start_file();
        repeat ($urandom_range(40, 1)) put_bits($urandom_range(1), 1);
      end
      send_file();
      files++;
      if (files == 4) wait_results_drained();
    end
  endtask

  task automatic test_stack_overflow();
    start_file();
    put_bits(0, 3);
    repeat (257) put_bits(0, 1);
    repeat (16) put_bits($urandom_range(1), 1);
    send_file();
  endtask

  // Output side: random stall, compare each accepted beat
  always @(negedge clk) begin
    result_stall <= idle_on && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (due_rd == due_wr) begin
        $error("unexpected result beat: symbol %0h status %0d last_of_run %0b",
               result_beat.symbol, result_beat.status, result_beat.last_of_run);
        mismatches++;
      end else begin
        want = due_mem[due_rd % DUE_DEPTH];
        due_rd++;
        if (result_beat.symbol !== want.symbol) begin
          $error("symbol: expected %0h, got %0h", want.symbol, result_beat.symbol);
          mismatches++;
        end
        if (result_beat.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_beat.status);
          mismatches++;
        end
        if (result_beat.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 result_beat.last_of_run);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (stream_valid && !stream_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    stream_valid = 1'b0;
    stream_beat  = '0;
    idle_on      = 1'b1;
    beats_sent   = 0;
    file_len     = 0;
    beat_count   = 0;
    decoder_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_leaf_tree();
    test_two_leaf_tree();
    test_partial_code();
    test_padding();
    test_truncated_stream();
    test_random_files();
    test_stack_overflow();

    wait_results_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
